// ----- rtl/core/scap_pkg.sv -----
// scap_pkg: field widths and parameter defaults shared by the scope capture block
// no dependencies; compile first
`default_nettype none

package scap_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 21;
    localparam int CNT_W    = 6;
    localparam int IDX_W    = 6;
    localparam int OFS_W    = 8;
    localparam int DIVC_W   = 5;

    localparam int RING_DEPTH_DEF   = 1024;
    localparam int FRAME_SIZE_DEF   = 64;
    localparam int SEARCH_LEN_DEF   = 256;
    localparam int MAX_CHANNELS_DEF = 32;

    localparam int OUT_DATA_W = 32;

endpackage

`default_nettype wire

// ----- rtl/core/scap_ram.sv -----
// scap_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies
`default_nettype none

module scap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/scope_capture_trigger.sv -----
// scope_capture_trigger: oscilloscope capture ring with a rising-edge trigger search
// depends on scap_pkg and scap_ram
`default_nettype none

// A capture word (tuser = 0) carries one channel sample; the word with tlast closes the
// sample frame, and its average is worked out by a serial divider, one quotient bit a
// cycle, then written to the ring, and no new input word is taken until then. A request
// word (tuser = 1) scans the search window through the single read port of the ring, one
// sample a cycle, then reads out FRAME_SIZE words, each through a read issue state and a
// data state, waiting in the issue state while the output is stalled. The ring needs no
// clearing pass: entries not yet written since reset read as zero.

module scope_capture_trigger #(
    parameter int RING_DEPTH   = scap_pkg::RING_DEPTH_DEF,
    parameter int FRAME_SIZE   = scap_pkg::FRAME_SIZE_DEF,
    parameter int SEARCH_LEN   = scap_pkg::SEARCH_LEN_DEF,
    parameter int MAX_CHANNELS = scap_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tuser,   // [0] mode
    input  wire logic        s_tlast,   // last_channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] frame_sample, [21:16] frame_index,
                                        // [29:22] trigger_offset, [31:30] zero
    output logic             m_tlast,   // last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    localparam int SW  = scap_pkg::SAMPLE_W;
    localparam int UW  = scap_pkg::SUM_W;
    localparam int CW  = scap_pkg::CNT_W;
    localparam int IW  = scap_pkg::IDX_W;
    localparam int OW  = scap_pkg::OFS_W;
    localparam int DW  = scap_pkg::DIVC_W;
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int PW  = $clog2(SEARCH_LEN);
    localparam int TOTAL     = FRAME_SIZE + SEARCH_LEN;
    localparam int TOTAL_MOD = TOTAL % RING_DEPTH;

    localparam logic [AW-1:0] LAST_ADDR  = AW'(RING_DEPTH - 1);
    localparam logic [AW-1:0] TMOD_A     = AW'(TOTAL_MOD);
    localparam logic [AW-1:0] TMOD_WRAP  = AW'(RING_DEPTH - TOTAL_MOD);
    localparam logic [31:0]   TOTAL_C    = 32'(TOTAL);
    localparam logic [CW-1:0] MAX_CH     = CW'(MAX_CHANNELS);
    localparam logic [PW-1:0] LAST_POS   = PW'(SEARCH_LEN - 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(FRAME_SIZE - 1);
    localparam logic [DW-1:0] DIV_STEPS  = DW'(UW - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_WR     = 3'd2;
    localparam logic [2:0] ST_SRCH   = 3'd3;
    localparam logic [2:0] ST_RD_ISS = 3'd4;
    localparam logic [2:0] ST_RD_DAT = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic [15:0]          slope_reg, slope_next;
    logic [31:0]          wc_reg, wc_next;
    logic [AW-1:0]        waddr_reg, waddr_next;
    logic                 full_reg, full_next;
    logic signed [UW-1:0] sum_reg, sum_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [UW-1:0]        dsh_reg, dsh_next;
    logic [CW:0]          rem_reg, rem_next;
    logic [CW-1:0]        divisor_reg, divisor_next;
    logic                 neg_reg, neg_next;
    logic [DW-1:0]        dcnt_reg, dcnt_next;
    logic [AW-1:0]        raddr_reg, raddr_next;
    logic [AW-1:0]        wstart_reg, wstart_next;
    logic [PW-1:0]        icnt_reg, icnt_next;
    logic                 ilive_reg, ilive_next;
    logic                 dlive_reg, dlive_next;
    logic [PW-1:0]        dpos_reg, dpos_next;
    logic [AW-1:0]        daddr_reg, daddr_next;
    logic                 rdok_reg, rdok_next;
    logic signed [SW-1:0] prev_reg, prev_next;
    logic [OW-1:0]        ofs_reg, ofs_next;
    logic [IW-1:0]        fcnt_reg, fcnt_next;
    logic                 mvalid_reg, mvalid_next;
    logic [SW-1:0]        osmp_reg, osmp_next;
    logic [IW-1:0]        oidx_reg, oidx_next;
    logic [OW-1:0]        oofs_reg, oofs_next;
    logic                 olast_reg, olast_next;

    logic                 ram_we;
    logic [SW-1:0]        ram_wdata;
    logic [SW-1:0]        ram_rdata;

    logic signed [UW-1:0] samp_ext;
    logic signed [UW-1:0] sum_new;
    logic [CW-1:0]        cnt_new;
    logic                 add_en;
    logic [CW:0]          trial;
    logic                 ge;
    logic [UW-1:0]        avg_full;
    logic signed [SW-1:0] curr;
    logic [SW:0]          diff;
    logic                 hit;
    logic [31:0]          pos_ext;
    logic [OW-1:0]        shown;
    logic [AW-1:0]        wstart_calc;
    logic [AW-1:0]        raddr_inc;
    logic                 load;

    scap_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr_reg),
        .wdata (ram_wdata),
        .raddr (raddr_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {2'b00, oofs_reg, oidx_reg, osmp_reg};
    assign m_tlast   = olast_reg;

    always_comb
    begin
        samp_ext = UW'(signed'(s_tdata));
        add_en   = (cnt_reg < MAX_CH);
        sum_new  = add_en ? (sum_reg + samp_ext) : sum_reg;
        cnt_new  = add_en ? (cnt_reg + 1'b1) : cnt_reg;

        trial = {rem_reg[CW-1:0], dsh_reg[UW-1]};
        ge    = (trial >= {1'b0, divisor_reg});

        avg_full  = neg_reg ? (~dsh_reg + 1'b1) : dsh_reg;
        ram_wdata = avg_full[SW-1:0];

        curr = rdok_reg ? signed'(ram_rdata) : '0;
        diff = {curr[SW-1], curr} - {prev_reg[SW-1], prev_reg};
        hit  = (dpos_reg != '0) && (prev_reg[SW-1] || (prev_reg == '0))
               && !curr[SW-1] && (curr != '0) && (diff > {1'b0, slope_reg});
        pos_ext = 32'(dpos_reg);
        shown   = (pos_ext > 32'd255) ? '1 : pos_ext[OW-1:0];

        if (wc_reg < TOTAL_C)
        begin
            wstart_calc = '0;
        end
        else if (waddr_reg >= TMOD_A)
        begin
            wstart_calc = waddr_reg - TMOD_A;
        end
        else
        begin
            wstart_calc = waddr_reg + TMOD_WRAP;
        end

        raddr_inc = (raddr_reg == LAST_ADDR) ? '0 : (raddr_reg + 1'b1);
    end

    always_comb
    begin
        state_next   = state_reg;
        slope_next   = slope_reg;
        wc_next      = wc_reg;
        waddr_next   = waddr_reg;
        full_next    = full_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        dsh_next     = dsh_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        dcnt_next    = dcnt_reg;
        raddr_next   = raddr_reg;
        wstart_next  = wstart_reg;
        icnt_next    = icnt_reg;
        ilive_next   = 1'b0;
        dlive_next   = 1'b0;
        dpos_next    = icnt_reg;
        daddr_next   = raddr_reg;
        rdok_next    = full_reg || (raddr_reg < waddr_reg);
        prev_next    = dlive_reg ? curr : prev_reg;
        ofs_next     = ofs_reg;
        fcnt_next    = fcnt_reg;
        osmp_next    = osmp_reg;
        oidx_next    = oidx_reg;
        oofs_next    = oofs_reg;
        olast_next   = olast_reg;
        ram_we       = 1'b0;
        load         = 1'b0;

        if (cfg_valid)
        begin
            slope_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser)
                    begin
                        raddr_next  = wstart_calc;
                        wstart_next = wstart_calc;
                        icnt_next   = '0;
                        ilive_next  = 1'b1;
                        state_next  = ST_SRCH;
                    end
                    else if (s_tlast)
                    begin
                        neg_next     = sum_new[UW-1];
                        dsh_next     = sum_new[UW-1] ? (~sum_new + 1'b1) : sum_new;
                        divisor_next = cnt_new;
                        rem_next     = '0;
                        dcnt_next    = DIV_STEPS;
                        sum_next     = '0;
                        cnt_next     = '0;
                        state_next   = ST_DIV;
                    end
                    else
                    begin
                        sum_next = sum_new;
                        cnt_next = cnt_new;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? (trial - {1'b0, divisor_reg}) : trial;
                dsh_next  = {dsh_reg[UW-2:0], ge};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    state_next = ST_WR;
                end
            end
            ST_WR:
            begin
                ram_we     = 1'b1;
                wc_next    = wc_reg + 1'b1;
                full_next  = full_reg || (waddr_reg == LAST_ADDR);
                waddr_next = ((waddr_reg == LAST_ADDR) || (wc_reg == '1)) ? '0
                             : (waddr_reg + 1'b1);
                state_next = ST_IDLE;
            end
            ST_SRCH:
            begin
                if (ilive_reg)
                begin
                    raddr_next = raddr_inc;
                    icnt_next  = icnt_reg + 1'b1;
                    ilive_next = (icnt_reg != LAST_POS);
                    dlive_next = 1'b1;
                end
                if (dlive_reg && (hit || (dpos_reg == LAST_POS)))
                begin
                    ofs_next   = hit ? shown : '0;
                    raddr_next = hit ? daddr_reg : wstart_reg;
                    ilive_next = 1'b0;
                    dlive_next = 1'b0;
                    fcnt_next  = '0;
                    state_next = ST_RD_ISS;
                end
            end
            ST_RD_ISS:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    state_next = ST_RD_DAT;
                end
            end
            ST_RD_DAT:
            begin
                load       = 1'b1;
                osmp_next  = curr;
                oidx_next  = fcnt_reg;
                oofs_next  = ofs_reg;
                olast_next = (fcnt_reg == LAST_IDX);
                if (fcnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    raddr_next = raddr_inc;
                    fcnt_next  = fcnt_reg + 1'b1;
                    state_next = ST_RD_ISS;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            mvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            mvalid_next = 1'b0;
        end
        else
        begin
            mvalid_next = mvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            slope_reg   <= '0;
            wc_reg      <= '0;
            waddr_reg   <= '0;
            full_reg    <= 1'b0;
            sum_reg     <= '0;
            cnt_reg     <= '0;
            dcnt_reg    <= '0;
            ilive_reg   <= 1'b0;
            dlive_reg   <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            slope_reg   <= slope_next;
            wc_reg      <= wc_next;
            waddr_reg   <= waddr_next;
            full_reg    <= full_next;
            sum_reg     <= sum_next;
            cnt_reg     <= cnt_next;
            dcnt_reg    <= dcnt_next;
            ilive_reg   <= ilive_next;
            dlive_reg   <= dlive_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsh_reg     <= dsh_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        raddr_reg   <= raddr_next;
        wstart_reg  <= wstart_next;
        icnt_reg    <= icnt_next;
        dpos_reg    <= dpos_next;
        daddr_reg   <= daddr_next;
        rdok_reg    <= rdok_next;
        prev_reg    <= prev_next;
        ofs_reg     <= ofs_next;
        fcnt_reg    <= fcnt_next;
        osmp_reg    <= osmp_next;
        oidx_reg    <= oidx_next;
        oofs_reg    <= oofs_next;
        olast_reg   <= olast_next;
    end

    a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        waddr_reg <= LAST_ADDR)
        else $error("ring write address out of range");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_CH)
        else $error("channel count above limit");

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("ring full flag dropped");

    a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (wc_reg == $past(wc_reg) + 32'd1) && (state_reg == ST_IDLE))
        else $error("write counter did not advance with ring write");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_DAT) |-> !mvalid_reg)
        else $error("output register overwritten");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench for scope_capture_trigger: streams channel words and frame requests, predicts
// every triggered display frame in a behavioral model and checks each output word
// depends on scap_pkg and the scope_capture_trigger rtl
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned RING_N   = scap_pkg::RING_DEPTH_DEF;
    localparam int unsigned FRAME_N  = scap_pkg::FRAME_SIZE_DEF;
    localparam int unsigned SEARCH_N = scap_pkg::SEARCH_LEN_DEF;
    localparam int          CHAN_MAX = scap_pkg::MAX_CHANNELS_DEF;

    localparam logic MODE_CAPTURE = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;

    typedef struct {
        logic signed [scap_pkg::SAMPLE_W-1:0] sample;
        logic [scap_pkg::IDX_W-1:0]           index;
        logic [scap_pkg::OFS_W-1:0]           offset;
        logic                                 last;
    } frame_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    // behavioral copy of the capture state
    logic signed [scap_pkg::SAMPLE_W-1:0] ring_model [0:RING_N-1];
    logic [31:0]                          written_count = '0;
    int                                   chan_sum = 0;
    int                                   chan_count = 0;
    logic [15:0]                          slope_reg = '0;

    frame_word_t frame_words_due[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int errors = 0;
    int channel_words = 0;
    int frame_requests = 0;
    int words_checked = 0;
    int slope_writes = 0;
    int stall_cycles = 0;

    int wave_level = 0;
    int wave_dir = 1;

    always #10 clk = ~clk;

    scope_capture_trigger u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    function automatic void accumulate_channel(input logic signed [15:0] smp,
                                               input logic closes);
        int avg;
        if (chan_count < CHAN_MAX)
        begin
            chan_sum += smp;
            chan_count++;
        end
        if (closes)
        begin
            avg = chan_sum / chan_count;
            ring_model[written_count % RING_N] = avg[15:0];
            written_count++;
            chan_sum = 0;
            chan_count = 0;
        end
    endfunction

    function automatic void predict_frame();
        logic [31:0] wstart;
        logic [31:0] start;
        int          offset;
        int          prev;
        int          curr;
        frame_word_t w;
        wstart = (written_count >= FRAME_N + SEARCH_N) ? written_count - (FRAME_N + SEARCH_N)
                                                       : 32'd0;
        offset = 0;
        for (int i = 1; i < SEARCH_N; i++)
        begin
            prev = ring_model[(wstart + i - 1) % RING_N];
            curr = ring_model[(wstart + i) % RING_N];
            if (offset == 0 && prev <= 0 && curr > 0 && (curr - prev) > int'(slope_reg))
                offset = i;
        end
        start = wstart + offset;
        for (int i = 0; i < FRAME_N; i++)
        begin
            w.sample = ring_model[(start + i) % RING_N];
            w.index  = scap_pkg::IDX_W'(i);
            w.offset = (offset > 255) ? 8'd255 : scap_pkg::OFS_W'(offset);
            w.last   = (i == FRAME_N - 1);
            frame_words_due.push_back(w);
        end
    endfunction

    function automatic void advance_wave(input int step);
        wave_level += wave_dir * step;
        if (wave_level > 30000)
        begin
            wave_level = 30000;
            wave_dir = -1;
        end
        else if (wave_level < -30000)
        begin
            wave_level = -30000;
            wave_dir = 1;
        end
    endfunction

    function automatic logic signed [15:0] wave_sample();
        int v;
        v = wave_level + int'($urandom_range(800, 0)) - 400;
        return v[15:0];
    endfunction

    task automatic push_word(input logic mode, input logic [15:0] smp, input logic closes);
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            s_tuser  <= 1'($urandom);
            s_tlast  <= 1'($urandom);
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= smp;
        s_tlast  <= closes;
        do @(posedge clk); while (!s_tready);
        if (mode == MODE_REQUEST)
        begin
            predict_frame();
            frame_requests++;
        end
        else
        begin
            accumulate_channel(smp, closes);
            channel_words++;
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (frame_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_trigger_slope(input logic [15:0] v);
        wait_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        slope_reg = v;
        slope_writes++;
    endtask

    task automatic test_empty_ring();
        push_word(MODE_REQUEST, 16'h7FFF, 1'b1);
    endtask

    task automatic test_channel_averaging();
        push_word(MODE_CAPTURE, 16'sd32767, 1'b1);
        push_word(MODE_CAPTURE, -16'sd32768, 1'b1);
        push_word(MODE_CAPTURE, -16'sd7, 1'b0);
        push_word(MODE_CAPTURE, 16'sd0, 1'b0);
        push_word(MODE_CAPTURE, 16'sd2, 1'b1);
        push_word(MODE_CAPTURE, 16'sd32767, 1'b0);
        push_word(MODE_CAPTURE, 16'sd32767, 1'b1);
        // a request in the middle of a frame leaves the running sum alone
        push_word(MODE_CAPTURE, -16'sd3, 1'b0);
        push_word(MODE_REQUEST, 16'h8000, 1'b1);
        push_word(MODE_CAPTURE, -16'sd2, 1'b1);
        // channels past the first 32 are dropped, the closing mark still counts
        for (int ch = 0; ch < CHAN_MAX; ch++)
            push_word(MODE_CAPTURE, -16'sd32768, 1'b0);
        push_word(MODE_CAPTURE, 16'sd32767, 1'b1);
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
    endtask

    task automatic test_trigger_slope();
        push_word(MODE_CAPTURE, -16'sd32768, 1'b1);
        push_word(MODE_CAPTURE, 16'sd32767, 1'b1);
        push_word(MODE_CAPTURE, -16'sd5, 1'b1);
        push_word(MODE_CAPTURE, 16'sd3, 1'b1);
        push_word(MODE_CAPTURE, -16'sd100, 1'b1);
        push_word(MODE_CAPTURE, 16'sd200, 1'b1);
        set_trigger_slope(16'd0);
        push_word(MODE_REQUEST, 16'h1234, 1'b0);
        set_trigger_slope(16'd65535);
        push_word(MODE_REQUEST, 16'hFFFF, 1'b1);
        set_trigger_slope(16'd65534);
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
        set_trigger_slope(16'd7);
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
        set_trigger_slope(16'd8);
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
        set_trigger_slope(16'd32767);
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
    endtask

    task automatic test_wave_capture();
        for (int n = 0; n < 60; n++)
        begin
            advance_wave($urandom_range(6000, 200));
            push_word(MODE_CAPTURE, wave_sample(), 1'b1);
            if (n % 20 == 19)
            begin
                push_word(MODE_REQUEST, 16'($urandom), 1'($urandom));
                set_trigger_slope(16'($urandom_range(12000, 0)));
            end
        end
        push_word(MODE_REQUEST, 16'h0000, 1'b0);
    endtask

    task automatic test_random_traffic();
        int sent;
        int roll;
        int nch;
        set_trigger_slope(16'($urandom_range(4000, 0)));
        sent = 0;
        while (sent < 125)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 10)
            begin
                push_word(MODE_REQUEST, 16'($urandom), 1'($urandom));
                sent++;
                if (roll < 3)
                    set_trigger_slope(16'($urandom));
            end
            else
            begin
                nch = (roll < 16) ? $urandom_range(36, 28) : $urandom_range(4, 1);
                advance_wave($urandom_range(9000, 300));
                for (int ch = 0; ch < nch; ch++)
                begin
                    push_word(MODE_CAPTURE, (roll >= 95) ? 16'($urandom) : wave_sample(),
                              ch == nch - 1);
                    sent++;
                    if ($urandom_range(49, 0) == 0)
                    begin
                        push_word(MODE_REQUEST, 16'($urandom), 1'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    // output side: random stalls and word-by-word compare
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : check_words
        frame_word_t due;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_words_due.size() == 0)
            begin
                $error("unexpected output word: frame_sample %0d", $signed(m_tdata[15:0]));
                errors++;
            end
            else
            begin
                due = frame_words_due.pop_front();
                words_checked++;
                if (m_tdata[15:0] !== due.sample)
                begin
                    $error("frame_sample: expected %0d, got %0d",
                           due.sample, $signed(m_tdata[15:0]));
                    errors++;
                end
                if (m_tdata[21:16] !== due.index)
                begin
                    $error("frame_index: expected %0d, got %0d", due.index, m_tdata[21:16]);
                    errors++;
                end
                if (m_tdata[29:22] !== due.offset)
                begin
                    $error("trigger_offset: expected %0d, got %0d", due.offset, m_tdata[29:22]);
                    errors++;
                end
                if (m_tlast !== due.last)
                begin
                    $error("last: expected %0d, got %0d", due.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < RING_N; i++)
            ring_model[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 14;
        rx_idle_pct = 71;
        test_empty_ring();
        test_channel_averaging();
        test_trigger_slope();

        tx_idle_pct = 71;
        rx_idle_pct = 14;
        test_wave_capture();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic();

        wait_until_drained();
        if (frame_words_due.size() != 0)
        begin
            $error("%0d output words never arrived", frame_words_due.size());
            errors++;
        end
        $display("covered %0d channel words and %0d frame requests, %0d output words checked",
                 channel_words, frame_requests, words_checked);
        $display("trigger slope written %0d times, %0d ring entries written",
                 slope_writes, written_count);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
